>>> src/multi_slot_software_timer_assert.svh
// ----------------------------------------------------------------------------
// Multi-slot software timer assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_SOFTWARE_TIMER_ASSERT_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define MSST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("msst assertion failed");

// Condition must never be true outside reset.
`define MSST_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("msst forbidden condition seen");

`else

`define MSST_ASSERT(label, clk, rst, prop)
`define MSST_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> src/msst_pkg.sv
// ----------------------------------------------------------------------------
// Multi-slot software timer package
// Shared constants, codes and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msst_pkg;

   localparam int DefSlots     = 16;
   localparam int DefCountBits = 32;

   // Expiries reported per tick at most
   localparam int MaxResults       = 16;
   localparam int ResultCountBits  = $clog2(MaxResults + 1);

   localparam int PeriodBits  = 32;
   localparam int HandlerBits = 8;
   localparam int SlotBits    = 4;
   localparam int StatusBits  = 2;

   localparam logic CmdStart = 1'b0;
   localparam logic CmdTick  = 1'b1;

   localparam logic KindStatus = 1'b0;
   localparam logic KindExpiry = 1'b1;

   localparam logic [StatusBits-1:0] StatusOk   = 2'd0;
   localparam logic [StatusBits-1:0] StatusFull = 2'd1;
   localparam logic [StatusBits-1:0] StatusZero = 2'd2;

   // Write strobes into the slot table
   typedef struct packed {
      logic count_we;   // remaining ticks
      logic slot_we;    // reload period, handler, mode
   } tbl_wr_type;

endpackage

`default_nettype wire

>>> src/multi_slot_software_timer.sv
// ----------------------------------------------------------------------------
// Multi-slot software timer
// Countdown timer slot table on one tick source, scanned a slot a cycle unless stalled.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  req      in   tvalid / tready    tuser = cmd, tdata = handler, period, mode
//  rsp      out  tvalid / tready    tuser = kind, tdata = status, slot, handler,
//                                   tlast = final result of the item
//
//  A tick item reads the slot table, decrements and writes it back one slot per
//  cycle unless stalled, through a single count unit and the slot table.
//  A start item searches the active bits in order for the first free slot;
//  a start with a zero period is turned away without a search.
//  A full result register stalls the scan when another expiry needs its place.
//  Reset clears the active bits and control state; the slot table is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_slot_software_timer_assert.svh"

module multi_slot_software_timer
   import msst_pkg::*;
#(
   parameter int SLOTS      = DefSlots,
   parameter int COUNT_BITS = DefCountBits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // handler_id[7:0], period[39:8], periodic[40]
   input  wire logic        req_tuser,  // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,  // status[1:0], slot[5:2], expired_handler[13:6]
   output logic             rsp_tuser,  // kind
   output logic             rsp_tlast
);

   localparam int IdxBits = $clog2(SLOTS);
   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_TICK,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   logic [IdxBits-1:0]         idx_ff, idx_in;
   logic [HandlerBits-1:0]     handler_ff, handler_in;
   logic [PeriodBits-1:0]      period_ff, period_in;
   logic                       periodic_ff, periodic_in;
   logic [SLOTS-1:0]           active_ff, active_in;
   logic [ResultCountBits-1:0] n_ff, n_in;

   logic                   pend_valid_ff, pend_valid_in;
   logic                   pend_kind_ff, pend_kind_in;
   logic [StatusBits-1:0]  pend_status_ff, pend_status_in;
   logic [SlotBits-1:0]    pend_slot_ff, pend_slot_in;
   logic [HandlerBits-1:0] pend_handler_ff, pend_handler_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [StatusBits-1:0]  rsp_status_ff, rsp_status_in;
   logic [SlotBits-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [HandlerBits-1:0] rsp_handler_ff, rsp_handler_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Request payload
   logic                   req_cmd;
   logic [HandlerBits-1:0] req_handler;
   logic [PeriodBits-1:0]  req_period;
   logic                   req_periodic;

   // Slot table and count unit
   tbl_wr_type             wr_ctrl;
   logic [COUNT_BITS-1:0]  wr_count;
   logic [IdxBits-1:0]     rd_addr;
   logic [COUNT_BITS-1:0]  rd_count;
   logic [COUNT_BITS-1:0]  rd_reload;
   logic [HandlerBits-1:0] rd_handler;
   logic                   rd_periodic;
   logic [COUNT_BITS-1:0]  count_dec;
   logic                   count_hit;
   logic [COUNT_BITS-1:0]  period_sat;

   logic out_free;
   logic push;
   logic expire;
   logic report;
   logic stall;

   assign req_cmd      = req_tuser;
   assign req_handler  = req_tdata[7:0];
   assign req_period   = req_tdata[39:8];
   assign req_periodic = req_tdata[40];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_handler_ff, rsp_slot_ff, rsp_status_ff};

   assign out_free = !rsp_valid_ff || rsp_tready;

   msst_count_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_count (
      .count_q    (rd_count),
      .period     (period_ff),
      .count_dec  (count_dec),
      .count_hit  (count_hit),
      .period_sat (period_sat)
   );

   msst_slot_table #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_BITS   (IdxBits)
   ) u_table (
      .clock       (clock),
      .wr_ctrl     (wr_ctrl),
      .wr_addr     (idx_ff),
      .wr_count    (wr_count),
      .wr_reload   (period_sat),
      .wr_handler  (handler_ff),
      .wr_periodic (periodic_ff),
      .rd_addr     (rd_addr),
      .rd_count    (rd_count),
      .rd_reload   (rd_reload),
      .rd_handler  (rd_handler),
      .rd_periodic (rd_periodic)
   );

   assign expire = (state_ff == ST_TICK) && active_ff[idx_ff] && count_hit;
   assign report = expire && (n_ff < ResultCountBits'(MaxResults));
   // Hold the scan while the pending expiry cannot move to the output
   assign stall  = report && pend_valid_ff && !out_free;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      handler_in      = handler_ff;
      period_in       = period_ff;
      periodic_in     = periodic_ff;
      active_in       = active_ff;
      n_in            = n_ff;
      pend_valid_in   = pend_valid_ff;
      pend_kind_in    = pend_kind_ff;
      pend_status_in  = pend_status_ff;
      pend_slot_in    = pend_slot_ff;
      pend_handler_in = pend_handler_ff;
      wr_ctrl         = '0;
      wr_count        = period_sat;
      rd_addr         = '0;
      push            = 1'b0;
      rsp_last_in     = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               handler_in    = req_handler;
               period_in     = req_period;
               periodic_in   = req_periodic;
               idx_in        = '0;
               n_in          = '0;
               pend_valid_in = 1'b0;
               if (req_cmd == CmdTick) begin
                  state_in = ST_TICK;
               end else if (req_period == '0) begin
                  pend_valid_in   = 1'b1;
                  pend_kind_in    = KindStatus;
                  pend_status_in  = StatusZero;
                  pend_slot_in    = '0;
                  pend_handler_in = '0;
                  state_in        = ST_FLUSH;
               end else begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (!active_ff[idx_ff]) begin
               wr_ctrl.count_we  = 1'b1;
               wr_ctrl.slot_we   = 1'b1;
               active_in[idx_ff] = 1'b1;
               pend_valid_in     = 1'b1;
               pend_kind_in      = KindStatus;
               pend_status_in    = StatusOk;
               pend_slot_in      = SlotBits'(idx_ff);
               pend_handler_in   = '0;
               state_in          = ST_FLUSH;
            end else if (idx_ff == LastIdx) begin
               pend_valid_in   = 1'b1;
               pend_kind_in    = KindStatus;
               pend_status_in  = StatusFull;
               pend_slot_in    = '0;
               pend_handler_in = '0;
               state_in        = ST_FLUSH;
            end else begin
               idx_in = idx_ff + IdxBits'(1);
            end
         end
         ST_TICK: begin
            rd_addr = stall ? idx_ff : IdxBits'(idx_ff + IdxBits'(1));
            if (!stall) begin
               if (active_ff[idx_ff]) begin
                  wr_ctrl.count_we = 1'b1;
                  wr_count = (count_hit && rd_periodic) ? rd_reload : count_dec;
                  if (count_hit && !rd_periodic) begin
                     active_in[idx_ff] = 1'b0;
                  end
               end
               if (report) begin
                  push            = pend_valid_ff;
                  rsp_last_in     = 1'b0;
                  pend_valid_in   = 1'b1;
                  pend_kind_in    = KindExpiry;
                  pend_status_in  = StatusOk;
                  pend_slot_in    = SlotBits'(idx_ff);
                  pend_handler_in = rd_handler;
                  n_in            = n_ff + ResultCountBits'(1);
               end
               if (idx_ff == LastIdx) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + IdxBits'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Result register: load from the pending item, else drain
      rsp_valid_in   = push || (rsp_valid_ff && !rsp_tready);
      rsp_kind_in    = push ? pend_kind_ff    : rsp_kind_ff;
      rsp_status_in  = push ? pend_status_ff  : rsp_status_ff;
      rsp_slot_in    = push ? pend_slot_ff    : rsp_slot_ff;
      rsp_handler_in = push ? pend_handler_ff : rsp_handler_ff;
      if (!push) begin
         rsp_last_in = rsp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         n_ff          <= '0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         n_ff          <= n_in;
         idx_ff        <= idx_in;
      end
      handler_ff      <= handler_in;
      period_ff       <= period_in;
      periodic_ff     <= periodic_in;
      pend_kind_ff    <= pend_kind_in;
      pend_status_ff  <= pend_status_in;
      pend_slot_ff    <= pend_slot_in;
      pend_handler_ff <= pend_handler_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_handler_ff  <= rsp_handler_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // Never overwrite a result the sink has not taken
   `MSST_ASSERT_NEVER(a_no_overwrite, clock, reset, push && rsp_valid_ff && !rsp_tready)
   // Nothing left over when a new item can enter
   `MSST_ASSERT_NEVER(a_idle_clean, clock, reset, req_tready && pend_valid_ff)
   // Reported expiries per tick stay within the result limit
   `MSST_ASSERT(a_count_cap, clock, reset, n_ff <= ResultCountBits'(MaxResults))
   // A stalled scan keeps its slot index
   `MSST_ASSERT(a_stall_hold, clock, reset, stall |=> $stable(idx_ff))

endmodule

`default_nettype wire

>>> src/msst_count_unit.sv
// ----------------------------------------------------------------------------
// Multi-slot software timer count unit
// Shared decrement and zero check for the slot scan, and period saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msst_count_unit
   import msst_pkg::*;
#(
   parameter int COUNT_BITS = DefCountBits
) (
   input  wire logic [COUNT_BITS-1:0] count_q,
   input  wire logic [PeriodBits-1:0] period,
   output logic      [COUNT_BITS-1:0] count_dec,
   output logic                       count_hit,
   output logic      [COUNT_BITS-1:0] period_sat
);

   localparam logic [63:0] CountMax = (64'd1 << COUNT_BITS) - 64'd1;

   logic [63:0] period_wide;

   assign count_dec  = count_q - COUNT_BITS'(1);
   assign count_hit  = (count_dec == '0);

   // Clamp periods that do not fit the counter
   assign period_wide = 64'(period);
   assign period_sat  = (period_wide > CountMax) ? COUNT_BITS'(CountMax)
                                                 : COUNT_BITS'(period_wide);

endmodule

`default_nettype wire

>>> src/msst_slot_table.sv
// ----------------------------------------------------------------------------
// Multi-slot software timer slot table
// Per-slot count, reload, handler and mode storage with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msst_slot_table
   import msst_pkg::*;
#(
   parameter int SLOTS      = DefSlots,
   parameter int COUNT_BITS = DefCountBits,
   parameter int IDX_BITS   = $clog2(SLOTS)
) (
   input  wire logic                   clock,
   input  wire tbl_wr_type             wr_ctrl,
   input  wire logic [IDX_BITS-1:0]    wr_addr,
   input  wire logic [COUNT_BITS-1:0]  wr_count,
   input  wire logic [COUNT_BITS-1:0]  wr_reload,
   input  wire logic [HandlerBits-1:0] wr_handler,
   input  wire logic                   wr_periodic,
   input  wire logic [IDX_BITS-1:0]    rd_addr,
   output logic      [COUNT_BITS-1:0]  rd_count,
   output logic      [COUNT_BITS-1:0]  rd_reload,
   output logic      [HandlerBits-1:0] rd_handler,
   output logic                        rd_periodic
);

   logic [COUNT_BITS-1:0]  count_mem   [SLOTS];
   logic [COUNT_BITS-1:0]  reload_mem  [SLOTS];
   logic [HandlerBits-1:0] handler_mem [SLOTS];
   logic                   mode_mem    [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_ctrl.count_we) begin
         count_mem[wr_addr] <= wr_count;
      end
      if (wr_ctrl.slot_we) begin
         reload_mem[wr_addr]  <= wr_reload;
         handler_mem[wr_addr] <= wr_handler;
         mode_mem[wr_addr]    <= wr_periodic;
      end
      rd_count    <= count_mem[rd_addr];
      rd_reload   <= reload_mem[rd_addr];
      rd_handler  <= handler_mem[rd_addr];
      rd_periodic <= mode_mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-slot software timer testbench
// Fills, overfills and drains the timer table with start and tick items under
// random back-pressure. A scoreboard tracks the slot table and checks every
// status and expiry item in order.
// ----------------------------------------------------------------------------

localparam int TimerSlots = msst_pkg::DefSlots;

typedef struct packed {
   logic       kind;
   logic [1:0] status;
   logic [3:0] slot;
   logic [7:0] handler;
   logic       last;
} timer_result_type;

class timer_scoreboard;
   bit [31:0]        remaining_ticks[TimerSlots];
   bit [31:0]        reload_period[TimerSlots];
   bit [7:0]         slot_handler[TimerSlots];
   bit               slot_periodic[TimerSlots];
   bit               slot_active[TimerSlots];
   timer_result_type expected_q[$];
   int               errors;

   function new();
      errors = 0;
      foreach (slot_active[i]) slot_active[i] = 1'b0;
   endfunction

   function int free_slots();
      int n;
      n = 0;
      foreach (slot_active[i]) if (!slot_active[i]) n++;
      return n;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Update the slot table for one accepted item and queue its results.
   function void note_item(logic cmd, logic [7:0] hid, logic [31:0] period, logic periodic);
      timer_result_type r;
      int               free_idx;
      int               n;
      r = '0;
      if (cmd == msst_pkg::CmdStart) begin
         r.kind = msst_pkg::KindStatus;
         r.last = 1'b1;
         free_idx = -1;
         for (int i = 0; i < TimerSlots; i++) begin
            if (!slot_active[i] && free_idx < 0) free_idx = i;
         end
         if (period == 0) begin
            r.status = msst_pkg::StatusZero;
         end else if (free_idx < 0) begin
            r.status = msst_pkg::StatusFull;
         end else begin
            remaining_ticks[free_idx] = period;
            reload_period[free_idx]   = period;
            slot_handler[free_idx]    = hid;
            slot_periodic[free_idx]   = periodic;
            slot_active[free_idx]     = 1'b1;
            r.status = msst_pkg::StatusOk;
            r.slot   = 4'(free_idx);
         end
         expected_q.push_back(r);
      end else begin
         n = 0;
         for (int i = 0; i < TimerSlots; i++) begin
            if (slot_active[i]) begin
               remaining_ticks[i] = remaining_ticks[i] - 1;
               if (remaining_ticks[i] == 0) begin
                  // report only the lowest expiries, but reload or free all
                  if (n < msst_pkg::MaxResults) begin
                     r = '0;
                     r.kind    = msst_pkg::KindExpiry;
                     r.status  = msst_pkg::StatusOk;
                     r.slot    = 4'(i);
                     r.handler = slot_handler[i];
                     expected_q.push_back(r);
                     n++;
                  end
                  if (slot_periodic[i]) remaining_ticks[i] = reload_period[i];
                  else slot_active[i] = 1'b0;
               end
            end
         end
         if (n > 0) expected_q[expected_q.size()-1].last = 1'b1;
      end
   endfunction

   function void check_result(timer_result_type got);
      timer_result_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected item: kind %0d status %0d slot %0d handler %0d last %0d",
                got.kind, got.status, got.slot, got.handler, got.last);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, actual %0d", want.kind, got.kind);
         errors++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         errors++;
      end
      if (got.slot !== want.slot) begin
         $error("slot: expected %0d, actual %0d", want.slot, got.slot);
         errors++;
      end
      if (got.handler !== want.handler) begin
         $error("expired_handler: expected %0d, actual %0d", want.handler, got.handler);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, got.last);
         errors++;
      end
   endfunction
endclass

module testbench;
   import msst_pkg::*;

   localparam int RandomItems   = 80;
   localparam int QuietItems    = 20;
   localparam int WatchdogLimit = 5000;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // handler_id[7:0], period[39:8], periodic[40]
   logic        req_tuser  = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // status[1:0], slot[5:2], expired_handler[13:6]
   logic        rsp_tuser;         // kind
   logic        rsp_tlast;

   bit              idling_on = 1'b1;
   int              idle_cycles = 0;
   timer_scoreboard timer_sb = new();

   multi_slot_software_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result side in random bursts.
   always begin
      @(posedge clock);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         timer_sb.check_result({rsp_tuser, rsp_tdata[1:0], rsp_tdata[5:2],
                                rsp_tdata[13:6], rsp_tlast});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [7:0] hid,
                            input logic [31:0] period, input logic periodic);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, periodic, period, hid};
      do @(posedge clock); while (!req_tready);
      timer_sb.note_item(cmd, hid, period, periodic);
   endtask

   task automatic send_tick();
      send_item(CmdTick, 8'($urandom), 32'($urandom), 1'($urandom));
   endtask

   initial begin
      logic [7:0]  hid;
      logic [31:0] period;
      logic        periodic;
      int          pick;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero period, a timer that never expires, fill the table,
      // overflow it, then ticks with no expiry and with a full burst.
      send_item(CmdStart, 8'hFF, 32'd0, 1'b1);
      send_item(CmdStart, 8'hA5, 32'hFFFF_FFFF, 1'b1);
      for (int i = 1; i < TimerSlots; i++) begin
         hid = (i == 1) ? 8'h00 : 8'(i * 17);
         send_item(CmdStart, hid, 32'd2, (i % 5) == 0);
      end
      send_item(CmdStart, 8'h3C, 32'h5A5A_A5A5, 1'b0);
      repeat (4) send_tick();

      for (int k = 0; k < RandomItems; k++) begin
         if (k == RandomItems - QuietItems) idling_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_tick();
         end else begin
            hid      = 8'($urandom);
            periodic = ($urandom_range(0, 6) == 0);
            pick     = $urandom_range(0, 9);
            if (pick == 0) period = 32'd0;
            // wide periods only while they are sure to be turned away
            else if (timer_sb.free_slots() == 0 && pick < 5) period = 32'($urandom);
            else period = 32'($urandom_range(1, 6));
            send_item(CmdStart, hid, period, periodic);
         end
      end
      req_tvalid <= 1'b0;

      while (timer_sb.pending() != 0) @(posedge clock);
      repeat (4 * (TimerSlots + 2)) @(posedge clock);

      if (timer_sb.errors == 0 && timer_sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
